/* rtl/itsf_pkg.sv */
// itsf_pkg: shared types and constants for the integer to single float converter
// no dependencies
package itsf_pkg;
	localparam logic [31:0] MostNegPat = 32'hCF00_0000;
	localparam logic [7:0] ExpBias = 8'd127;
	localparam logic [7:0] HalfWay = 8'd128;

	// stage 1 to stage 2 payload
	typedef struct packed {
		logic        sign;
		logic        zero;
		logic        most_neg;
		logic [31:0] mag;
	} mag_t;

	// stage 2 to stage 3 payload
	typedef struct packed {
		logic        sign;
		logic        zero;
		logic        most_neg;
		logic [4:0]  lead;
		logic [31:0] norm;
	} norm_t;
endpackage

/* rtl/itsf_norm.sv */
// itsf_norm: leading one search and normalizing shift, combinational
// depends on itsf_pkg
module itsf_norm (
	input  itsf_pkg::mag_t  mag,
	output itsf_pkg::norm_t norm
);
	logic [4:0] lead;

	// priority search for the leading one
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag.mag[i]) begin
				lead = 5'(i);
			end
		end
	end

	// move the leading one to bit 31
	always_comb begin
		norm.sign     = mag.sign;
		norm.zero     = mag.zero;
		norm.most_neg = mag.most_neg;
		norm.lead     = lead;
		norm.norm     = mag.mag << (5'd31 - lead);
	end
endmodule

/* rtl/int_to_single_float_top.sv */
// int_to_single_float_top: three stage int32 to ieee single converter
// depends on itsf_pkg and itsf_norm
//
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall  | int_value [31:0] signed
// output  | out       | out_valid/out_stall| float_bits [31:0]
//
// one transaction per cycle sustained while the output is not stalled
// stages: magnitude, normalize, round and pack
// reset clears only the stage valid bits
// a stall at the output holds every full stage; bubbles are filled
module int_to_single_float_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] int_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_bits
);
	logic vld_s1, vld_s2, vld_s3;
	logic adv_s1, adv_s2, adv_s3;
	itsf_pkg::mag_t  mag_s1;
	itsf_pkg::norm_t norm_c, norm_s2;
	logic [31:0] res_c, res_s3;

	// stage enables: a stage loads when it is empty or its content moves on
	assign adv_s3 = !vld_s3 || !out_stall;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	// stage 1: sign, special cases, magnitude
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mag_s1.sign     <= int_value[31];
			mag_s1.zero     <= (int_value == 32'sd0);
			mag_s1.most_neg <= (int_value == 32'sh8000_0000);
			mag_s1.mag      <= int_value[31] ? (~int_value + 32'd1) : int_value;
		end
	end

	itsf_norm u_norm (
		.mag  (mag_s1),
		.norm (norm_c)
	);

	// stage 2: normalized magnitude
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			norm_s2 <= norm_c;
		end
	end

	// stage 3 logic: round to nearest even and pack
	always_comb begin
		logic [7:0]  dropped;
		logic [23:0] frac;
		logic [7:0]  expo;
		logic        rnd;
		dropped = norm_s2.norm[7:0];
		expo    = {3'd0, norm_s2.lead} + itsf_pkg::ExpBias;
		rnd     = (dropped > itsf_pkg::HalfWay) ||
			((dropped == itsf_pkg::HalfWay) && norm_s2.norm[8]);
		frac    = {1'b0, norm_s2.norm[30:8]} + {23'd0, rnd};
		if (frac[23]) begin
			expo = expo + 8'd1;
		end
		if (norm_s2.zero) begin
			res_c = 32'd0;
		end else if (norm_s2.most_neg) begin
			res_c = itsf_pkg::MostNegPat;
		end else begin
			res_c = {norm_s2.sign, expo, frac[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			res_s3 <= res_c;
		end
	end

	assign out_valid  = vld_s3;
	assign float_bits = res_s3;

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(float_bits))
		else $error("result changed under stall");

	// full pipeline with output stall backs up the input
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && vld_s3 && out_stall |-> in_stall)
		else $error("input not stalled on full pipeline");

	// a sign bit in the result only comes from a negative stage 2 item
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && adv_s3 && !norm_s2.sign |=> !float_bits[31])
		else $error("sign mismatch");
endmodule

/* bench/int_to_single_float_top_test.sv */
// int_to_single_float_top_test: self-checking bench for the int32 to single float converter
// depends on itsf_pkg and int_to_single_float_top
module int_to_single_float_top_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] int_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] float_bits;

	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic [31:0] float_queue[$];

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned NumDirected = 22;
	localparam int unsigned NumRandom = 500;

	// directed rows: input value, expected pattern, expected known
	typedef struct {
		logic [31:0] value;
		logic [31:0] pattern;
		logic        known;
	} stim_row_t;

	stim_row_t directed_tab[NumDirected] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1},
		'{32'h8000_0000, itsf_pkg::MostNegPat, 1'b1},
		'{32'h0000_0001, 32'h3F80_0000, 1'b1},
		'{32'hFFFF_FFFF, 32'hBF80_0000, 1'b1},
		'{32'h7FFF_FFFF, 32'h4F00_0000, 1'b1},
		'{32'h8000_0001, 32'hCF00_0000, 1'b1},
		'{32'h0000_0002, 32'h4000_0000, 1'b1},
		'{32'h00FF_FFFF, 32'h4B7F_FFFF, 1'b1},
		'{32'h0100_0000, 32'h4B80_0000, 1'b1},
		'{32'h0100_0001, 32'h4B80_0000, 1'b1},
		'{32'h0100_0003, 32'h4B80_0002, 1'b1},
		'{32'h0100_0002, 32'h0,         1'b0},
		'{32'h0200_0002, 32'h0,         1'b0},
		'{32'h0200_0006, 32'h0,         1'b0},
		'{32'h0200_0003, 32'h0,         1'b0},
		'{32'h7FFF_FF80, 32'h0,         1'b0},
		'{32'h7FFF_FFBF, 32'h0,         1'b0},
		'{32'h7FFF_FFC0, 32'h0,         1'b0},
		'{32'hFEFF_FFFF, 32'h0,         1'b0},
		'{32'hAAAA_AAAA, 32'h0,         1'b0},
		'{32'h5555_5555, 32'h0,         1'b0},
		'{32'h4000_0000, 32'h4E80_0000, 1'b1}
	};

	int_to_single_float_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.int_value(int_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.float_bits(float_bits)
	);

	// clock
	always #6 clk = ~clk;

	// round to nearest even conversion of one signed integer
	function automatic logic [31:0] int_to_float(input logic [31:0] value);
		logic        sign;
		logic [31:0] mag;
		logic [31:0] norm;
		logic [7:0]  expo;
		logic [23:0] frac;
		logic [7:0]  dropped;
		int          lead;
		sign = value[31];
		lead = 0;
		if (value == 32'h0)
			return 32'h0;
		if (value == 32'h8000_0000)
			return itsf_pkg::MostNegPat;
		mag = sign ? (~value + 32'd1) : value;
		for (int i = 0; i < 32; i++)
			if (mag[i])
				lead = i;
		norm = mag << (31 - lead);
		expo = 8'(lead) + itsf_pkg::ExpBias;
		frac = {1'b0, norm[30:8]};
		dropped = norm[7:0];
		if (dropped > itsf_pkg::HalfWay ||
				(dropped == itsf_pkg::HalfWay && frac[0])) begin
			frac = frac + 24'd1;
			if (frac[23]) begin
				expo = expo + 8'd1;
				frac = '0;
			end
		end
		return {sign, expo, frac[22:0]};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		err_count++;
	endtask

	// send one transaction, honoring sender idle rate
	task automatic send_int(input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		int_value <= value;
		// stall is sampled at the edge itself, before registers update
		@(posedge clk iff !in_stall);
	endtask

	// random integer with varied magnitudes, including round-point patterns
	function automatic logic [31:0] rand_int();
		logic [31:0] v;
		int unsigned sh;
		v = $urandom();
		sh = $urandom_range(31);
		case ($urandom_range(3))
			0: v = v;
			1: v = v >> sh;
			2: v = {v[31], 31'(v[30:0] >> sh)};
			default: v = (v & 32'hFFFF_FF00) | {24'h0, 8'h80};
		endcase
		return v;
	endfunction

	// output check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (float_queue.size() == 0)
				report_mismatch("unexpected result", float_bits, 32'h0);
			else begin
				logic [31:0] want;
				want = float_queue.pop_front();
				if (float_bits !== want)
					report_mismatch("float_bits", float_bits, want);
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("[int_to_single_float_top] ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [31:0] v;
		int unsigned drain;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 23;
		recv_idle_pct = 79;
		for (int i = 0; i < NumDirected; i++) begin
			v = directed_tab[i].value;
			if (directed_tab[i].known)
				float_queue.push_back(directed_tab[i].pattern);
			else
				float_queue.push_back(int_to_float(v));
			send_int(v);
		end
		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom / 3) begin
				send_idle_pct = 79;
				recv_idle_pct = 23;
			end else if (i == 2 * NumRandom / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			v = rand_int();
			float_queue.push_back(int_to_float(v));
			send_int(v);
		end
		in_valid <= 1'b0;
		drain = 0;
		while (float_queue.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (err_count == 0 && float_queue.size() == 0)
			$display("[int_to_single_float_top] OK");
		else
			$display("[int_to_single_float_top] ERROR");
		$finish;
	end
endmodule
